// ===== design/asn1_token_scanner_assert.svh =====
`ifndef ASN1_TOKEN_SCANNER_ASSERT_SVH
`define ASN1_TOKEN_SCANNER_ASSERT_SVH
// Assertion helpers, clocked on clk; ATS_ASSERT is quiet in reset, ATS_ASSERT_RST is not.
`define ATS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== design/ats_pkg.sv =====
package ats_pkg;
  localparam int NKW = 25;
  localparam int KW_BIT = 13;
  localparam int KW_OCTET = 14;
  localparam int MAX_TOKEN_CHARS_DEF = 255;
  localparam int MAX_SUFFIX_CHARS_DEF = 31;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam logic [31:0] POS_MAX = 32'hFFFFFFFF;

  localparam logic [5:0] K_INVALID = 6'd0;
  localparam logic [5:0] K_END = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_NUMBER = 6'd3;
  localparam logic [5:0] K_KW0 = 6'd4;
  localparam logic [5:0] K_ASSIGN = 6'd29;
  localparam logic [5:0] K_RANGE = 6'd30;
  localparam logic [5:0] K_LBRACE = 6'd31;
  localparam logic [5:0] K_RBRACE = 6'd32;
  localparam logic [5:0] K_LBRACK = 6'd33;
  localparam logic [5:0] K_RBRACK = 6'd34;
  localparam logic [5:0] K_LPAREN = 6'd35;
  localparam logic [5:0] K_RPAREN = 6'd36;
  localparam logic [5:0] K_COMMA = 6'd37;
  localparam logic [5:0] K_SEMI = 6'd38;
  localparam logic [5:0] K_EQUAL = 6'd39;
  localparam logic [5:0] K_DOT = 6'd40;
  localparam logic [5:0] K_MINUS = 6'd41;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_MINUS, M_COMMENT, M_COLON1, M_COLON2,
    M_DOT1, M_SPACES, M_SUFFIX
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] line;
    logic [31:0] start;
    logic [31:0] stop;
    logic        last;
  } tok_t;

  // keyword text, 14 chars max, char 0 in the low byte
  typedef logic [13:0][7:0] kwtext_t;

  function automatic kwtext_t kw_str(input string s);
    kwtext_t r;
    r = '0;
    for (int i = 0; i < s.len(); i++) r[i] = s[i];
    return r;
  endfunction

  function automatic kwtext_t kw_text(input logic [4:0] i);
    case (i)
      5'd0: return kw_str("BEGIN");
      5'd1: return kw_str("END");
      5'd2: return kw_str("DEFINITIONS");
      5'd3: return kw_str("EXPLICIT");
      5'd4: return kw_str("IMPLICIT");
      5'd5: return kw_str("AUTOMATIC");
      5'd6: return kw_str("TAGS");
      5'd7: return kw_str("SEQUENCE");
      5'd8: return kw_str("CHOICE");
      5'd9: return kw_str("ENUMERATED");
      5'd10: return kw_str("INTEGER");
      5'd11: return kw_str("BOOLEAN");
      5'd12: return kw_str("REAL");
      5'd13: return kw_str("BIT");
      5'd14: return kw_str("OCTET");
      5'd15: return kw_str("VisibleString");
      5'd16: return kw_str("UTF8String");
      5'd17: return kw_str("SIZE");
      5'd18: return kw_str("OPTIONAL");
      5'd19: return kw_str("DEFAULT");
      5'd20: return kw_str("INCLUDE");
      5'd21: return kw_str("EXPORTS");
      5'd22: return kw_str("IMPORTS");
      5'd23: return kw_str("FROM");
      5'd24: return kw_str("ALL");
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] i);
    case (i)
      5'd0: return 4'd5;   5'd1: return 4'd3;   5'd2: return 4'd11;
      5'd3: return 4'd8;   5'd4: return 4'd8;   5'd5: return 4'd9;
      5'd6: return 4'd4;   5'd7: return 4'd8;   5'd8: return 4'd6;
      5'd9: return 4'd10;  5'd10: return 4'd7;  5'd11: return 4'd7;
      5'd12: return 4'd4;  5'd13: return 4'd3;  5'd14: return 4'd5;
      5'd15: return 4'd13; 5'd16: return 4'd10; 5'd17: return 4'd4;
      5'd18: return 4'd8;  5'd19: return 4'd7;  5'd20: return 4'd7;
      5'd21: return 4'd7;  5'd22: return 4'd7;  5'd23: return 4'd4;
      5'd24: return 4'd3;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {["A":"Z"], ["a":"z"]};
  endfunction
  function automatic logic id_cont(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_" || b == "-";
  endfunction
  function automatic logic [31:0] pos_inc(input logic [31:0] p);
    return (p == POS_MAX) ? p : p + 32'd1;
  endfunction
endpackage

// ===== design/ats_front.sv =====
module ats_front #(
  parameter int MAX_TOKEN_CHARS = ats_pkg::MAX_TOKEN_CHARS_DEF,
  parameter int MAX_SUFFIX_CHARS = ats_pkg::MAX_SUFFIX_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   source_byte,
  output ats_pkg::tok_t tok0,
  output logic         tok0_vld,
  output ats_pkg::tok_t tok1,
  output logic         tok1_vld
);
  import ats_pkg::*;

  localparam kwtext_t STR_TXT = kw_str("STRING");

  mode_t       mode, mode_next;
  logic [NKW-1:0] cand, cand_next;
  logic [7:0]  tcnt, tcnt_next;
  logic [4:0]  scnt, scnt_next;
  logic        smatch, smatch_next;
  logic        octet, octet_next;
  logic [23:0] line, line_next;
  logic [31:0] pos;
  logic [31:0] tstart, tstart_next;
  logic [23:0] tline, tline_next;

  logic [4:0]  kw_hit;
  logic        kw_any;
  logic [5:0]  pend_kind;
  logic [7:0]  b;

  assign b = source_byte;

  // keyword mask filter for position idx
  function automatic logic [NKW-1:0] kw_filter(input logic [NKW-1:0] m,
                                               input logic [7:0] idx,
                                               input logic [7:0] c);
    logic [NKW-1:0] r;
    kwtext_t t;
    r = m;
    for (int i = 0; i < NKW; i++) begin
      t = kw_text(5'(i));
      if (idx >= {4'd0, kw_len(5'(i))} || t[idx[3:0]] != c) r[i] = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    kw_any = 1'b0;
    kw_hit = 5'd0;
    for (int i = NKW - 1; i >= 0; i--) begin
      if (cand[i] && {4'd0, kw_len(5'(i))} == tcnt) begin
        kw_any = 1'b1;
        kw_hit = 5'(i);
      end
    end
  end

  always_comb begin
    case (mode)
      M_IDENT: begin
        if (!kw_any) pend_kind = K_IDENT;
        else if (kw_hit == 5'(KW_BIT) || kw_hit == 5'(KW_OCTET)) pend_kind = K_INVALID;
        else pend_kind = K_KW0 + {1'b0, kw_hit};
      end
      M_NUMBER: pend_kind = K_NUMBER;
      M_MINUS:  pend_kind = K_MINUS;
      M_COLON1: pend_kind = K_IDENT;
      M_DOT1:   pend_kind = K_DOT;
      M_SUFFIX: begin
        if (smatch && scnt == 5'd6)
          pend_kind = octet ? K_KW0 + 6'(KW_OCTET) : K_KW0 + 6'(KW_BIT);
        else pend_kind = K_INVALID;
      end
      default: pend_kind = K_INVALID;
    endcase
  end

  always_comb begin
    logic busy;
    logic [5:0] k;
    mode_next = mode; cand_next = cand; tcnt_next = tcnt; scnt_next = scnt;
    smatch_next = smatch; octet_next = octet; line_next = line;
    tstart_next = tstart; tline_next = tline;
    tok0 = '0; tok1 = '0; tok0_vld = 1'b0; tok1_vld = 1'b0;
    busy = 1'b0;
    k = K_IDENT;
    if (b == 8'd0) begin
      if (mode != M_IDLE && mode != M_COMMENT) begin
        tok0 = '{pend_kind, tline, tstart, pos, 1'b0};
        tok0_vld = 1'b1;
        tok1 = '{K_END, line, pos, pos, 1'b1};
        tok1_vld = 1'b1;
      end else begin
        tok0 = '{K_END, line, pos, pos, 1'b1};
        tok0_vld = 1'b1;
      end
      mode_next = M_IDLE; cand_next = '1; tcnt_next = '0; scnt_next = '0;
      smatch_next = 1'b1; octet_next = 1'b0; line_next = 24'd1;
      tstart_next = '0; tline_next = 24'd1;
    end else begin
      busy = 1'b1;
      case (mode)
        M_IDLE: busy = 1'b0;
        M_IDENT: begin
          if (id_cont(b) && tcnt < 8'(MAX_TOKEN_CHARS)) begin
            cand_next = kw_filter(cand, tcnt, b);
            tcnt_next = tcnt + 8'd1;
          end else if (kw_any && (kw_hit == 5'(KW_BIT) || kw_hit == 5'(KW_OCTET))
                       && b == " ") begin
            mode_next = M_SPACES;
            octet_next = (kw_hit == 5'(KW_OCTET));
            scnt_next = '0;
            smatch_next = 1'b1;
          end else busy = 1'b0;
        end
        M_NUMBER: begin
          if (is_digit(b) && tcnt < 8'(MAX_TOKEN_CHARS)) tcnt_next = tcnt + 8'd1;
          else busy = 1'b0;
        end
        M_MINUS: begin
          if (b == "-") mode_next = M_COMMENT;
          else if (is_digit(b)) begin
            mode_next = M_NUMBER;
            tcnt_next = 8'd2;
          end else busy = 1'b0;
        end
        M_COMMENT: begin
          if (b == "\n") begin
            mode_next = M_IDLE;
            busy = 1'b0;
          end
        end
        M_COLON1: begin
          if (b == ":") mode_next = M_COLON2;
          else busy = 1'b0;
        end
        M_COLON2: begin
          if (b == "=") begin
            tok0 = '{K_ASSIGN, tline, tstart, pos_inc(pos), 1'b0};
            tok0_vld = 1'b1;
            mode_next = M_IDLE;
          end else busy = 1'b0;
        end
        M_DOT1: begin
          if (b == ".") begin
            tok0 = '{K_RANGE, tline, tstart, pos_inc(pos), 1'b0};
            tok0_vld = 1'b1;
            mode_next = M_IDLE;
          end else busy = 1'b0;
        end
        M_SPACES: begin
          if (b == "S") begin
            mode_next = M_SUFFIX;
            scnt_next = 5'd1;
            smatch_next = 1'b1;
          end else if (b != " ") busy = 1'b0;
        end
        M_SUFFIX: begin
          if (id_cont(b) && scnt < 5'(MAX_SUFFIX_CHARS)) begin
            if (scnt >= 5'd6 || STR_TXT[scnt[2:0]] != b) smatch_next = 1'b0;
            scnt_next = scnt + 5'd1;
          end else busy = 1'b0;
        end
        default: busy = 1'b0;
      endcase
      // pending token closed by a byte it does not take
      if (!busy && mode != M_IDLE && mode != M_COMMENT) begin
        tok0 = '{pend_kind, tline, tstart, pos, 1'b0};
        tok0_vld = 1'b1;
        mode_next = M_IDLE;
      end
      if (!busy) begin
        if (b == " " || b == "\t" || b == "\r") begin
        end else if (b == "\n") begin
          if (line < LINE_MAX) line_next = line + 24'd1;
        end else begin
          tstart_next = pos;
          tline_next = line;
          if (is_alpha(b) || b == "_") begin
            mode_next = M_IDENT;
            cand_next = kw_filter('1, 8'd0, b);
            tcnt_next = 8'd1;
          end else if (is_digit(b)) begin
            mode_next = M_NUMBER;
            tcnt_next = 8'd1;
          end else if (b == "-") mode_next = M_MINUS;
          else if (b == ":") mode_next = M_COLON1;
          else if (b == ".") mode_next = M_DOT1;
          else begin
            case (b)
              "{": k = K_LBRACE;
              "}": k = K_RBRACE;
              "[": k = K_LBRACK;
              "]": k = K_RBRACK;
              "(": k = K_LPAREN;
              ")": k = K_RPAREN;
              ",": k = K_COMMA;
              ";": k = K_SEMI;
              "=": k = K_EQUAL;
              default: k = K_IDENT;
            endcase
            if (tok0_vld) begin
              tok1 = '{k, line, pos, pos_inc(pos), 1'b1};
              tok1_vld = 1'b1;
            end else begin
              tok0 = '{k, line, pos, pos_inc(pos), 1'b1};
              tok0_vld = 1'b1;
            end
          end
        end
      end
      if (tok0_vld && !tok1_vld) tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; cand <= '1; tcnt <= '0; scnt <= '0; smatch <= 1'b1;
      octet <= 1'b0; line <= 24'd1; pos <= '0; tstart <= '0; tline <= 24'd1;
    end else if (take) begin
      mode <= mode_next; cand <= cand_next; tcnt <= tcnt_next; scnt <= scnt_next;
      smatch <= smatch_next; octet <= octet_next; line <= line_next;
      tstart <= tstart_next; tline <= tline_next;
      pos <= (b == 8'd0) ? 32'd0 : pos_inc(pos);
    end
  end
endmodule

// ===== design/ats_queue.sv =====
module ats_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  ats_pkg::tok_t w0,
  input  logic          w0_en,
  input  ats_pkg::tok_t w1,
  input  logic          w1_en,
  output logic          room2,
  output ats_pkg::tok_t rd,
  output logic          rd_vld,
  input  logic          rd_en
);
  import ats_pkg::*;
  localparam int AW = $clog2(DEPTH);

  tok_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic [AW:0] nw;
  logic do_rd;

  assign do_rd = rd_en && rd_vld;
  assign rd_vld = cnt != '0;
  assign rd = mem[rp];
  assign room2 = cnt <= (AW+1)'(DEPTH - 2);
  assign nw = (AW+1)'(w0_en) + (AW+1)'(w1_en);

  always_ff @(posedge clk) begin
    if (w0_en) mem[wp] <= w0;
    if (w1_en) mem[w0_en ? AW'(wp + AW'(1)) : wp] <= w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + nw[AW-1:0];
      if (do_rd) rp <= rp + AW'(1);
      cnt <= cnt + nw - (AW+1)'(do_rd);
    end
  end
endmodule

// ===== design/asn1_token_scanner.sv =====
// ASN.1 lexer: one source byte per push (0 ends the input and restarts the
// scanner), up to two tokens per byte popped in order, each with kind, start
// line and byte span. A byte is taken each cycle push is high and full is low;
// full rises when the four-entry token queue cannot hold two more tokens.
// A token is queued as its closing byte is taken and pops after older ones.
`include "asn1_token_scanner_assert.svh"
module asn1_token_scanner #(
  parameter int MAX_TOKEN_CHARS = ats_pkg::MAX_TOKEN_CHARS_DEF,
  parameter int MAX_SUFFIX_CHARS = ats_pkg::MAX_SUFFIX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind,
  output logic [23:0] token_line,
  output logic [31:0] start_offset,
  output logic [31:0] end_offset,
  output logic        last_of_step
);
  import ats_pkg::*;

  tok_t t0, t1, rd;
  logic v0, v1, room2, rd_vld, take;

  assign full = !room2;
  assign take = push && room2;

  ats_front #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS), .MAX_SUFFIX_CHARS(MAX_SUFFIX_CHARS))
    u_front (.clk, .rst, .take, .source_byte, .tok0(t0), .tok0_vld(v0),
             .tok1(t1), .tok1_vld(v1));

  ats_queue #(.DEPTH(4)) u_q (.clk, .rst, .w0(t0), .w0_en(take && v0),
    .w1(t1), .w1_en(take && v1), .room2, .rd, .rd_vld, .rd_en(pop));

  assign empty = !rd_vld;
  assign token_kind = rd.kind;
  assign token_line = rd.line;
  assign start_offset = rd.start;
  assign end_offset = rd.stop;
  assign last_of_step = rd.last;

  `ATS_ASSERT(a_two_needs_first, v1 |-> v0, "second token without first")
  `ATS_ASSERT(a_last_set, (v0 && !v1) |-> t0.last, "single token not marked last")
  `ATS_ASSERT(a_end_last, (!empty && token_kind == K_END) |-> last_of_step,
              "end token not last")
  `ATS_ASSERT_RST(a_rst_empty, $past(rst) |-> empty, "queue not empty after reset")
endmodule
